// ===== hw/rtl/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C master sequencer package
// Shared widths, command codes and the beat type passed from front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

	// Width of the phase tick counter.
	localparam int TickBits = 16;
	// Width of the phase length registers.
	localparam int PhaseLenBits = 16;
	// Compare width: wide enough for either operand plus one.
	localparam int CmpBits = ((TickBits > PhaseLenBits) ? TickBits : PhaseLenBits) + 1;

	// Configuration port.
	localparam int CfgIdxBits = 1;
	localparam int CfgDataBits = 16;
	localparam logic [CfgIdxBits-1:0] CFG_LONG_PHASE = 1'd0;
	localparam logic [CfgIdxBits-1:0] CFG_SHORT_PHASE = 1'd1;
	localparam logic [PhaseLenBits-1:0] LONG_PHASE_RESET = 16'd5;
	localparam logic [PhaseLenBits-1:0] SHORT_PHASE_RESET = 16'd2;

	// Command codes carried in func.
	localparam logic [2:0] FUNC_TICK = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ = 3'd4;
	localparam logic [2:0] CMD_SACK = 3'd5;
	localparam logic [2:0] CMD_RACK = 3'd6;
	// Spare code with no command behind it; it counts as a plain tick.
	localparam logic [2:0] FUNC_SPARE = 3'd7;

	// Classified input beat held in the queue between front and back.
	typedef struct packed {
		logic       is_cmd;
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       ack_bit;
		logic       sda_level;
	} q_item_t;

	// Handshake between queue head and back end.
	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

	// One result beat.
	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       sda_value;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       rx_ack;
		logic       refused;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cm_ifs.sv =====
// ---------------------------------------------------------------------------
// I2C master sequencer channel interfaces
// Valid/ready channels for command/tick beats in and result beats out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] tx_byte;
	logic       ack_bit;
	logic       sda_level;

	modport source (output valid, output func, output tx_byte, output ack_bit,
		output sda_level, input ready);
	modport sink (input valid, input func, input tx_byte, input ack_bit,
		input sda_level, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_drive;
	logic       sda_value;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       rx_ack;
	logic       refused;

	modport source (output valid, output scl_level, output sda_drive, output sda_value,
		output busy_res, output done_res, output rx_byte, output rx_ack,
		output refused, input ready);
	modport sink (input valid, input scl_level, input sda_drive, input sda_value,
		input busy_res, input done_res, input rx_byte, input rx_ack,
		input refused, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2cm_front.sv =====
// ---------------------------------------------------------------------------
// I2C master sequencer front end
// Accepts input beats, classifies them as command or tick, and holds them
// in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
	input  wire              clk,
	input  wire              arst_n,
	i2cm_cmd_if.sink         cmd,
	output i2cm_pkg::q_head_t head,
	input  wire              pop
);

	i2cm_pkg::q_item_t       slot_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              count_q;
	i2cm_pkg::q_item_t       item_in;
	logic                    push;
	logic                    do_pop;

	// Classify the incoming beat; the spare code counts as a plain tick.
	always_comb begin
		item_in.is_cmd    = (cmd.func != i2cm_pkg::FUNC_TICK)
			&& (cmd.func != i2cm_pkg::FUNC_SPARE);
		item_in.cmd       = cmd.func;
		item_in.tx_byte   = cmd.tx_byte;
		item_in.ack_bit   = cmd.ack_bit;
		item_in.sda_level = cmd.sda_level;
	end

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign do_pop    = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cm_back.sv =====
// ---------------------------------------------------------------------------
// I2C master sequencer back end
// Steps the SCL/SDA phase sequencer once per queued beat and registers the
// result beat; holds the phase length registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire i2cm_pkg::q_head_t                 head,
	output logic                                   pop,
	i2cm_res_if.source                             res,
	input  wire                                    cfg_we,
	input  wire [i2cm_pkg::CfgIdxBits-1:0]         cfg_index,
	input  wire [i2cm_pkg::CfgDataBits-1:0]        cfg_data
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_START_A = 4'd1;
	localparam logic [3:0] PH_START_B = 4'd2;
	localparam logic [3:0] PH_START_C = 4'd3;
	localparam logic [3:0] PH_STOP_A  = 4'd4;
	localparam logic [3:0] PH_STOP_B  = 4'd5;
	localparam logic [3:0] PH_SETUP   = 4'd6;
	localparam logic [3:0] PH_HIGH    = 4'd7;
	localparam logic [3:0] PH_LOW     = 4'd8;
	localparam logic [3:0] PH_HOLD    = 4'd9;
	localparam logic [3:0] PH_PRE     = 4'd10;

	localparam int TB = i2cm_pkg::TickBits;
	localparam int CB = i2cm_pkg::CmpBits;

	logic [i2cm_pkg::PhaseLenBits-1:0] long_q;
	logic [i2cm_pkg::PhaseLenBits-1:0] short_q;

	logic [3:0]    phase_q,  phase_n;
	logic [2:0]    bits_q,   bits_n;
	logic [7:0]    shift_q,  shift_n;
	logic [TB-1:0] tick_q,   tick_n;
	logic [2:0]    ccmd_q,   ccmd_n;
	logic          scl_q,    scl_n;
	logic          sda_q,    sda_n;
	logic          oe_q,     oe_n;

	logic                    out_valid_q;
	i2cm_pkg::res_t          out_q;
	i2cm_pkg::res_t          out_n;
	logic                    step;
	logic [i2cm_pkg::PhaseLenBits-1:0] dur;
	logic [CB-1:0]           tick_inc;
	logic                    phase_end;
	logic                    done;
	logic [7:0]              shift_adv;

	// A beat is stepped when the output register is free or being emptied.
	assign step = head.valid && (!out_valid_q || res.ready);
	assign pop  = step;

	// Phase length for the current phase.
	always_comb begin
		dur = long_q;
		if ((phase_q == PH_SETUP)
			|| ((phase_q == PH_HOLD) && (ccmd_q == i2cm_pkg::CMD_READ))) begin
			dur = short_q;
		end
	end

	assign tick_inc  = CB'(tick_q) + CB'(1);
	assign phase_end = !((tick_inc < CB'(dur)) && (tick_q != {TB{1'b1}}));
	assign shift_adv = {shift_q[6:0], head.item.sda_level};

	// Next state of the sequencer for one beat.
	always_comb begin
		phase_n = phase_q;
		bits_n  = bits_q;
		shift_n = shift_q;
		tick_n  = tick_q;
		ccmd_n  = ccmd_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		oe_n    = oe_q;
		done    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (head.item.is_cmd) begin
				ccmd_n = head.item.cmd;
				tick_n = '0;
				bits_n = 3'd0;
				unique case (head.item.cmd)
					i2cm_pkg::CMD_START: begin
						oe_n = 1'b1; scl_n = 1'b1; sda_n = 1'b1; phase_n = PH_START_A;
					end
					i2cm_pkg::CMD_STOP: begin
						oe_n = 1'b1; scl_n = 1'b1; sda_n = 1'b0; phase_n = PH_STOP_A;
					end
					i2cm_pkg::CMD_WRITE: begin
						oe_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0;
						shift_n = head.item.tx_byte; bits_n = 3'd7; phase_n = PH_PRE;
					end
					i2cm_pkg::CMD_READ: begin
						oe_n = 1'b0; scl_n = 1'b1;
						shift_n = 8'd0; bits_n = 3'd7; phase_n = PH_HIGH;
					end
					i2cm_pkg::CMD_SACK: begin
						oe_n = 1'b1; scl_n = 1'b0; sda_n = head.item.ack_bit;
						phase_n = PH_SETUP;
					end
					default: begin
						oe_n = 1'b0; scl_n = 1'b1; shift_n = 8'd0; phase_n = PH_HIGH;
					end
				endcase
			end
		end else if (!phase_end) begin
			tick_n = tick_inc[TB-1:0];
		end else begin
			tick_n = '0;
			unique case (phase_q)
				PH_START_A: begin sda_n = 1'b0; phase_n = PH_START_B; end
				PH_START_B: begin scl_n = 1'b0; phase_n = PH_START_C; end
				PH_START_C: begin phase_n = PH_IDLE; done = 1'b1; end
				PH_STOP_A:  begin sda_n = 1'b1; phase_n = PH_STOP_B; end
				PH_STOP_B:  begin phase_n = PH_IDLE; done = 1'b1; end
				PH_PRE:     begin sda_n = shift_q[7]; phase_n = PH_SETUP; end
				PH_SETUP:   begin scl_n = 1'b1; phase_n = PH_HIGH; end
				PH_HIGH: begin
					if ((ccmd_q == i2cm_pkg::CMD_RACK)
						|| (ccmd_q == i2cm_pkg::CMD_READ)) begin
						shift_n = shift_adv;
						phase_n = PH_HOLD;
					end else begin
						scl_n   = 1'b0;
						phase_n = PH_LOW;
					end
				end
				PH_HOLD:    begin scl_n = 1'b0; phase_n = PH_LOW; end
				PH_LOW: begin
					if ((bits_q != 3'd0) && (ccmd_q == i2cm_pkg::CMD_WRITE)) begin
						bits_n  = bits_q - 3'd1;
						shift_n = {shift_q[6:0], 1'b0};
						sda_n   = shift_q[6];
						phase_n = PH_SETUP;
					end else if ((bits_q != 3'd0) && (ccmd_q == i2cm_pkg::CMD_READ)) begin
						bits_n  = bits_q - 3'd1;
						scl_n   = 1'b1;
						phase_n = PH_HIGH;
					end else begin
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
				end
				default:    begin phase_n = PH_IDLE; end
			endcase
		end
	end

	// Result beat built from the stepped state.
	always_comb begin
		out_n.scl_level = scl_n;
		out_n.sda_drive = oe_n;
		out_n.sda_value = oe_n & sda_n;
		out_n.busy_res  = (phase_n != PH_IDLE);
		out_n.done_res  = done;
		out_n.rx_byte   = (done && (ccmd_q == i2cm_pkg::CMD_READ)) ? shift_n : 8'd0;
		out_n.rx_ack    = done && (ccmd_q == i2cm_pkg::CMD_RACK) && shift_n[0];
		out_n.refused   = (phase_q != PH_IDLE) && head.item.is_cmd;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bits_q  <= 3'd0;
			shift_q <= 8'd0;
			tick_q  <= '0;
			ccmd_q  <= 3'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			oe_q    <= 1'b1;
		end else if (step) begin
			phase_q <= phase_n;
			bits_q  <= bits_n;
			shift_q <= shift_n;
			tick_q  <= tick_n;
			ccmd_q  <= ccmd_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			oe_q    <= oe_n;
		end
	end

	// Phase length registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= i2cm_pkg::LONG_PHASE_RESET;
			short_q <= i2cm_pkg::SHORT_PHASE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == i2cm_pkg::CFG_LONG_PHASE) begin
				long_q <= cfg_data;
			end
			if (cfg_index == i2cm_pkg::CFG_SHORT_PHASE) begin
				short_q <= cfg_data;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= out_n;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.scl_level = out_q.scl_level;
	assign res.sda_drive = out_q.sda_drive;
	assign res.sda_value = out_q.sda_value;
	assign res.busy_res  = out_q.busy_res;
	assign res.done_res  = out_q.done_res;
	assign res.rx_byte   = out_q.rx_byte;
	assign res.rx_ack    = out_q.rx_ack;
	assign res.refused   = out_q.refused;

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Command and tick beats drive a timed SCL/SDA phase sequencer; each beat
// gives one result beat with pin levels, busy, done and received data.
// ---------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  cmd       in   valid / ready    func, tx_byte, ack_bit, sda_level
//  res       out  valid / ready    scl_level, sda_drive, sda_value, busy_res,
//                                  done_res, rx_byte, rx_ack, refused
//  cfg       in   cfg_we           cfg_index, cfg_data
//
// One beat per cycle sustained while res is ready; a beat is written into the queue
// at the edge that accepts it, then one sequencer step moves its result into the
// output register, where it is offered until it is taken.
// While a result waits to be taken the queue takes up to two more beats, then
// ready drops until the result leaves.
// Reset is asynchronous and leaves SCL and SDA driven high, the sequencer
// idle and the queue empty, with phase lengths of five (long) and two (short)
// ticks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer (
	input  wire                             clk,
	input  wire                             arst_n,
	i2cm_cmd_if.sink                        cmd,
	i2cm_res_if.source                      res,
	input  wire                             cfg_we,
	input  wire [i2cm_pkg::CfgIdxBits-1:0]  cfg_index,
	input  wire [i2cm_pkg::CfgDataBits-1:0] cfg_data
);

	i2cm_pkg::q_head_t head;
	logic              pop;

	// Accept and classify beats.
	i2cm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.pop    (pop)
	);

	// Run the bus phases.
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
